// ===== hdl/accma_pkg.sv =====
// Shared constants, state encoding and control bundles for the accelerometer moving average.
`default_nettype none

package accma_pkg;

  // Default sizes of the history ring and the sample fields.
  localparam int unsigned HISTORY_DEPTH_DEF = 64;
  localparam int unsigned SAMPLE_WIDTH_DEF  = 16;

  // Width of the window length register port.
  localparam int unsigned WINDOW_CFG_WIDTH = 7;

  // Number of accelerometer axes handled side by side.
  localparam int unsigned AXES = 3;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ACCUM   = 6'b000010,
    S_DRAIN   = 6'b000100,
    S_DIVINIT = 6'b001000,
    S_DIVIDE  = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // take the input transaction, write history, seed sums
    logic issue;      // read one older history entry
    logic div_start;  // load magnitudes and signs into the divider
    logic div_step;   // one restoring division step on every axis
    logic out_load;   // move the quotients into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic single;      // window length is one, nothing to read back
    logic last_issue;  // the read being issued is the oldest in the window
    logic div_done;    // all quotient bits are formed
    logic out_free;    // output register can take a new result this cycle
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/accma_ctrl.sv =====
// Controller state machine sequencing accept, history walk, division and output.
`default_nettype none

module accma_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  accma_pkg::status_t  status,
  output accma_pkg::cmd_t     cmd
);

  import accma_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // New transactions are taken only while idle.
  assign in_stall = (state != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.single ? S_DIVINIT : S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.issue = 1'b1;
        if (status.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last read lands in the sums during this cycle.
        state_next = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (status.div_done) begin
          state_next = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/accma_datapath.sv =====
// Datapath: window register, history memory, per-axis sums, serial divider and output register.
`default_nettype none

module accma_datapath #(
  parameter int unsigned HISTORY_DEPTH = accma_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH  = accma_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      window_length_wr_en,
  input  logic [accma_pkg::WINDOW_CFG_WIDTH-1:0]    window_length,
  input  logic signed [SAMPLE_WIDTH-1:0]            accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0]            accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0]            accel_z,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]            avg_x,
  output logic signed [SAMPLE_WIDTH-1:0]            avg_y,
  output logic signed [SAMPLE_WIDTH-1:0]            avg_z,
  input  accma_pkg::cmd_t                           cmd,
  output accma_pkg::status_t                        status
);

  import accma_pkg::*;

  localparam int unsigned AW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned NW   = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUMW = SAMPLE_WIDTH + $clog2(HISTORY_DEPTH);
  localparam int unsigned STW  = $clog2(SUMW + 1);
  localparam int unsigned RW   = NW + 1;
  localparam int unsigned EW   = AXES * SAMPLE_WIDTH;

  localparam logic [AW-1:0]  LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [NW-1:0]  MAX_WIN   = NW'(HISTORY_DEPTH);
  localparam logic [NW-1:0]  ONE_WIN   = NW'(1);
  localparam logic [STW-1:0] STEPS     = STW'(SUMW);

  // Ring step backward with wrap for any depth.
  function automatic logic [AW-1:0] addr_prev(input logic [AW-1:0] a);
    addr_prev = (a == '0) ? LAST_ADDR : a - AW'(1);
  endfunction

  logic [NW-1:0]              window_len;
  logic [AW-1:0]              wpos;
  logic [AW-1:0]              rptr;
  logic [NW-1:0]              remaining;
  logic [EW-1:0]              mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0]   entry_valid;
  logic [EW-1:0]              rdata;
  logic                       rd_live;
  logic                       rd_pend;
  logic signed [SAMPLE_WIDTH-1:0] sample [AXES];
  logic signed [SUMW-1:0]     acc [AXES];
  logic [SUMW-1:0]            dvd [AXES];
  logic [NW-1:0]              rem [AXES];
  logic [AXES-1:0]            neg;
  logic [STW-1:0]             step_cnt;
  logic [RW-1:0]              rem_sh [AXES];
  logic [AXES-1:0]            ge;
  logic [SUMW-1:0]            quot [AXES];

  assign sample[0] = accel_x;
  assign sample[1] = accel_y;
  assign sample[2] = accel_z;

  // Window length register, saturated into 1..HISTORY_DEPTH on write.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= ONE_WIN;
    end else if (window_length_wr_en) begin
      if (window_length == '0) begin
        window_len <= ONE_WIN;
      end else if (32'(window_length) > HISTORY_DEPTH) begin
        window_len <= MAX_WIN;
      end else begin
        window_len <= NW'(window_length);
      end
    end
  end

  // History memory: written on accept, read one entry per issue.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[wpos] <= {accel_z, accel_y, accel_x};
    end
    if (cmd.issue) begin
      rdata <= mem[rptr];
    end
  end

  // Per-entry written flags; an unwritten entry contributes zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_pend     <= 1'b0;
      rd_live     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        entry_valid[wpos] <= 1'b1;
      end
      rd_pend <= cmd.issue;
      rd_live <= entry_valid[rptr];
    end
  end

  // Write position and read walk through the ring.
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos <= '0;
    end else if (cmd.accept) begin
      wpos <= (wpos == LAST_ADDR) ? '0 : wpos + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rptr      <= addr_prev(wpos);
      remaining <= window_len - ONE_WIN;
    end else if (cmd.issue) begin
      rptr      <= addr_prev(rptr);
      remaining <= remaining - ONE_WIN;
    end
  end

  // Sums: seeded with the new sample, then one older entry per cycle.
  always_ff @(posedge clk) begin
    for (int a = 0; a < AXES; a++) begin
      if (cmd.accept) begin
        acc[a] <= SUMW'(sample[a]);
      end else if (rd_pend && rd_live) begin
        acc[a] <= acc[a] + SUMW'($signed(rdata[a*SAMPLE_WIDTH +: SAMPLE_WIDTH]));
      end
    end
  end

  // One restoring division step per axis, shared divisor.
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      rem_sh[a] = {rem[a], dvd[a][SUMW-1]};
      ge[a]     = (rem_sh[a] >= {1'b0, window_len});
      quot[a]   = neg[a] ? (~dvd[a] + SUMW'(1)) : dvd[a];
    end
  end

  // Divider registers: magnitude in, quotient shifts in from the right.
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      step_cnt <= '0;
      for (int a = 0; a < AXES; a++) begin
        neg[a] <= acc[a][SUMW-1];
        dvd[a] <= acc[a][SUMW-1] ? SUMW'(-acc[a]) : SUMW'(acc[a]);
        rem[a] <= '0;
      end
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt + STW'(1);
      for (int a = 0; a < AXES; a++) begin
        rem[a] <= ge[a] ? NW'(rem_sh[a] - {1'b0, window_len}) : NW'(rem_sh[a]);
        dvd[a] <= {dvd[a][SUMW-2:0], ge[a]};
      end
    end
  end

  // Output register: holds a result until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      avg_x <= SAMPLE_WIDTH'(quot[0]);
      avg_y <= SAMPLE_WIDTH'(quot[1]);
      avg_z <= SAMPLE_WIDTH'(quot[2]);
    end
  end

  // Status back to the controller.
  assign status.single     = (window_len == ONE_WIN);
  assign status.last_issue = (remaining == ONE_WIN);
  assign status.div_done   = (step_cnt == STEPS);
  assign status.out_free   = !out_valid || !out_stall;

endmodule

`default_nettype wire

// ===== hdl/accel_moving_average.sv =====
// Top level of the accelerometer boxcar moving average: controller plus datapath.
// The history walk reads one memory entry per cycle and the divider forms one quotient bit per
// cycle. A new input transaction is taken only after the previous result has been loaded into
// the output register, so a stalled output holds off the next transaction.
// Reset (synchronous, rst high) clears the history flags, ring position and window to 1.
`default_nettype none

module accel_moving_average #(
  parameter int unsigned HISTORY_DEPTH = accma_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned SAMPLE_WIDTH  = accma_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   window_length_wr_en,
  input  logic [accma_pkg::WINDOW_CFG_WIDTH-1:0] window_length,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]         accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0]         accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0]         accel_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]         avg_x,
  output logic signed [SAMPLE_WIDTH-1:0]         avg_y,
  output logic signed [SAMPLE_WIDTH-1:0]         avg_z
);

  import accma_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  accma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage, arithmetic and output register.
  accma_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .window_length_wr_en (window_length_wr_en),
    .window_length       (window_length),
    .accel_x             (accel_x),
    .accel_y             (accel_y),
    .accel_z             (accel_z),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .avg_x               (avg_x),
    .avg_y               (avg_y),
    .avg_z               (avg_z),
    .cmd                 (cmd),
    .status              (status)
  );

endmodule

`default_nettype wire

// ===== hdl/accma_checker.sv =====
// Port-level checks for the moving average, bound to the top level.
`default_nettype none

module accma_checker #(
  parameter int unsigned SAMPLE_WIDTH = accma_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SAMPLE_WIDTH-1:0] avg_x,
  input logic [SAMPLE_WIDTH-1:0] avg_y,
  input logic [SAMPLE_WIDTH-1:0] avg_z
);

  // No result is left over from before a reset.
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set right after reset");

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again while a transaction is in flight");

  // A new result only appears at the end of a busy period.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in flight");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(avg_x) && $stable(avg_y) && $stable(avg_z)))
    else $error("stalled result changed");

endmodule

bind accel_moving_average accma_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_accma_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .avg_x     (avg_x),
  .avg_y     (avg_y),
  .avg_z     (avg_z)
);

`default_nettype wire

// ===== test/tb_accel_moving_average.sv =====
// Self-checking testbench for the accelerometer boxcar moving average.
`timescale 1ns / 1ps

module tb_accel_moving_average;
  import accma_pkg::*;

  localparam int SW = SAMPLE_WIDTH_DEF;
  localparam int DEPTH = HISTORY_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 120;
  localparam int PHASES = 12;
  localparam int PHASE_SAMPLES = 150;

  // One sample or one mean, three axes.
  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] z;
  } triple_t;

  typedef enum {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [WINDOW_CFG_WIDTH-1:0] win;
    triple_t smp;
    bit typed;
    triple_t want;
  } stim_row_t;

  logic clk;
  logic rst;
  logic window_length_wr_en;
  logic [WINDOW_CFG_WIDTH-1:0] window_length;
  logic in_valid;
  logic in_stall;
  logic signed [SW-1:0] accel_x;
  logic signed [SW-1:0] accel_y;
  logic signed [SW-1:0] accel_z;
  logic out_valid;
  logic out_stall;
  logic signed [SW-1:0] avg_x;
  logic signed [SW-1:0] avg_y;
  logic signed [SW-1:0] avg_z;

  // Predictor state: history ring, write slot and the saturated window.
  triple_t hist_mem [DEPTH];
  int hist_pos;
  int window_len;

  triple_t expected_avgs [$];
  stim_row_t script [16];
  bit no_idle;
  int errors;
  int samples_sent;
  int avgs_checked;
  int windows_set;
  int idle_cycles;

  accel_moving_average dut (
    .clk                 (clk),
    .rst                 (rst),
    .window_length_wr_en (window_length_wr_en),
    .window_length       (window_length),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .accel_x             (accel_x),
    .accel_y             (accel_y),
    .accel_z             (accel_z),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .avg_x               (avg_x),
    .avg_y               (avg_y),
    .avg_z               (avg_z)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Write the new sample into the ring, then average the newest window_len entries.
  // Signed division in SystemVerilog truncates toward zero, as the block must.
  function automatic triple_t boxcar_mean(input triple_t smp);
    longint sum_x;
    longint sum_y;
    longint sum_z;
    int slot;
    triple_t mean;
    sum_x = 0;
    sum_y = 0;
    sum_z = 0;
    hist_mem[hist_pos] = smp;
    for (int j = 0; j < window_len; j++) begin
      slot = (hist_pos + DEPTH - j) % DEPTH;
      sum_x += hist_mem[slot].x;
      sum_y += hist_mem[slot].y;
      sum_z += hist_mem[slot].z;
    end
    mean.x = SW'(sum_x / window_len);
    mean.y = SW'(sum_y / window_len);
    mean.z = SW'(sum_z / window_len);
    hist_pos = (hist_pos + 1) % DEPTH;
    return mean;
  endfunction

  // Random field value in one of three styles: full range, extremes only, near zero.
  function automatic logic [SW-1:0] pick_field(input int style);
    logic [SW-1:0] v;
    case (style)
      1: begin
        case ($urandom_range(0, 3))
          0: v = 16'h7fff;
          1: v = 16'h8000;
          2: v = 16'hffff;
          default: v = 16'h0000;
        endcase
      end
      2: v = SW'($urandom_range(0, 64) - 32);
      default: v = SW'($urandom);
    endcase
    return v;
  endfunction

  // Write the window register once every expected mean has come back.
  task automatic set_window(input logic [WINDOW_CFG_WIDTH-1:0] value);
    while (expected_avgs.size() != 0) @(posedge clk);
    window_length_wr_en <= 1'b1;
    window_length <= value;
    @(posedge clk);
    window_length_wr_en <= 1'b0;
    window_len = (value == 0) ? 1 : ((value > DEPTH) ? DEPTH : int'(value));
    windows_set++;
  endtask

  // Offer one sample, hold it until taken, then record the mean it should produce.
  task automatic send_sample(input triple_t smp, input bit typed, input triple_t want);
    triple_t mean;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= smp.x;
    accel_y <= smp.y;
    accel_z <= smp.z;
    do @(posedge clk); while (in_stall);
    mean = boxcar_mean(smp);
    expected_avgs.push_back(typed ? want : mean);
    samples_sent++;
  endtask

  // Output back-pressure in random bursts; none once the run turns calm.
  initial begin
    int burst_left;
    burst_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!no_idle && burst_left == 0 && $urandom_range(0, 7) == 0)
        burst_left = $urandom_range(1, 15);
      if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each output transaction against the oldest expected mean.
  always @(posedge clk) begin
    triple_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_avgs.size() == 0) begin
        $error("unexpected output transaction: avg_x %0d avg_y %0d avg_z %0d",
               avg_x, avg_y, avg_z);
        errors++;
      end else begin
        want = expected_avgs.pop_front();
        avgs_checked++;
        if (avg_x !== want.x) begin
          $error("avg_x: expected %0d, got %0d", want.x, avg_x);
          errors++;
        end
        if (avg_y !== want.y) begin
          $error("avg_y: expected %0d, got %0d", want.y, avg_y);
          errors++;
        end
        if (avg_z !== want.z) begin
          $error("avg_z: expected %0d, got %0d", want.z, avg_z);
          errors++;
        end
      end
    end
  end

  // Stop a hung run: too many cycles in a row without any transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d means outstanding.", expected_avgs.size());
      $display("FAIL accel_moving_average");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    triple_t smp;
    triple_t none;
    int style;
    logic [WINDOW_CFG_WIDTH-1:0] win;

    rst = 1'b1;
    in_valid = 1'b0;
    window_length_wr_en = 1'b0;
    window_length = '0;
    accel_x = '0;
    accel_y = '0;
    accel_z = '0;
    no_idle = 1'b0;
    errors = 0;
    samples_sent = 0;
    avgs_checked = 0;
    windows_set = 0;
    idle_cycles = 0;
    none = '0;

    // Predictor starts from the reset state: empty ring, window of one.
    for (int i = 0; i < DEPTH; i++) hist_mem[i] = '0;
    hist_pos = 0;
    window_len = 1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed rows. The first rows run with the reset window of one, so each mean is
    // its own sample; the window of two on odd negative sums shows truncation toward
    // zero; the window of 64 right after reset reads never-written zero entries.
    script = '{
      '{ROW_SAMPLE, 7'd0,   '{16'sh7fff, 16'sh8000, 16'sh0000}, 1'b1,
        '{16'sh7fff, 16'sh8000, 16'sh0000}},
      '{ROW_SAMPLE, 7'd0,   '{16'shffff, 16'sh0001, 16'sh1234}, 1'b1,
        '{16'shffff, 16'sh0001, 16'sh1234}},
      '{ROW_WINDOW, 7'd0,   '{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, none},
      '{ROW_SAMPLE, 7'd0,   '{16'shffff, 16'sh0001, 16'sh8000}, 1'b1,
        '{16'shffff, 16'sh0001, 16'sh8000}},
      '{ROW_WINDOW, 7'd2,   '{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, none},
      '{ROW_SAMPLE, 7'd0,   '{16'shfffe, 16'sh0002, 16'sh8000}, 1'b1,
        '{16'shffff, 16'sh0001, 16'sh8000}},
      '{ROW_WINDOW, 7'd64,  '{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, none},
      '{ROW_SAMPLE, 7'd0,   '{16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, none},
      '{ROW_WINDOW, 7'd127, '{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, none},
      '{ROW_SAMPLE, 7'd0,   '{16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, none},
      '{ROW_WINDOW, 7'd65,  '{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, none},
      '{ROW_SAMPLE, 7'd0,   '{16'sh5555, 16'shaaaa, 16'sh00ff}, 1'b0, none},
      '{ROW_WINDOW, 7'd1,   '{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, none},
      '{ROW_SAMPLE, 7'd0,   '{16'sh8000, 16'sh7fff, 16'sh8000}, 1'b1,
        '{16'sh8000, 16'sh7fff, 16'sh8000}},
      '{ROW_WINDOW, 7'd63,  '{16'sh0000, 16'sh0000, 16'sh0000}, 1'b0, none},
      '{ROW_SAMPLE, 7'd0,   '{16'sh0f0f, 16'shf0f0, 16'sh3c3c}, 1'b0, none}
    };

    foreach (script[r]) begin
      if (script[r].kind == ROW_WINDOW) begin
        // Withdraw the sample just taken so it is not offered a second time.
        in_valid <= 1'b0;
        set_window(script[r].win);
      end else begin
        send_sample(script[r].smp, script[r].typed, script[r].want);
      end
    end

    // Random phases, each under its own window; the last one runs without idling.
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: win = WINDOW_CFG_WIDTH'($urandom_range(0, 1));
        1: win = WINDOW_CFG_WIDTH'($urandom_range(DEPTH, 127));
        2: win = WINDOW_CFG_WIDTH'($urandom_range(2, 8));
        default: win = WINDOW_CFG_WIDTH'($urandom_range(0, 127));
      endcase
      in_valid <= 1'b0;
      set_window(win);
      if (p == PHASES - 1) no_idle = 1'b1;
      style = $urandom_range(0, 3);
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        smp.x = pick_field(style);
        smp.y = pick_field(style);
        smp.z = pick_field(style);
        send_sample(smp, 1'b0, none);
      end
    end
    in_valid <= 1'b0;

    // Drain, then give the block time to show any stray output.
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d samples under %0d window writes, including saturating ones;",
             samples_sent, windows_set);
    $display("compared %0d three-axis means, %0d mismatches.", avgs_checked, errors);
    if (errors == 0) begin
      $display("PASS accel_moving_average");
    end else begin
      $display("FAIL accel_moving_average");
    end
    $finish;
  end

endmodule
